// ----- rtl/core/lffc_pkg.sv -----
// Shared types and codes for the LED fade and flash controller.
// Used by lffc_regs, lffc_engine and led_fade_flash_controller; depends on nothing.
package lffc_pkg;

  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_SET   = 3'd1,
    REQ_STEP  = 3'd2,
    REQ_FADE  = 3'd3,
    REQ_DARK  = 3'd4,
    REQ_FLASH = 3'd5,
    REQ_ON    = 3'd6,
    REQ_OFF   = 3'd7
  } req_type_t;

  typedef enum logic [1:0] {
    REG_PWM_MODE    = 2'd0,
    REG_MAX_LEVEL   = 2'd1,
    REG_BLINK_TICKS = 2'd2,
    REG_FADE_TICKS  = 2'd3
  } reg_idx_t;

  localparam logic        PWM_MODE_RST    = 1'b1;
  localparam logic [15:0] MAX_LEVEL_RST   = 16'd255;
  localparam logic [15:0] BLINK_TICKS_RST = 16'd100;
  localparam logic [15:0] FADE_TICKS_RST  = 16'd1;
  localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;

  typedef struct packed {
    logic        pwm_mode;
    logic [15:0] max_level;
    logic [15:0] blink_ticks;
    logic [15:0] fade_ticks;
  } cfg_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [15:0]        level_value;
    logic signed [16:0] step_value;
    logic [7:0]         flash_count;
  } req_t;

  typedef struct packed {
    logic [15:0] drive_level;
    logic        drive_written;
    logic        accepted;
    logic        busy_flag;
    logic [15:0] current_level;
    logic [15:0] target_level;
  } res_t;

endpackage

// ----- rtl/core/led_fade_flash_controller.sv -----
// Top level of the LED fade and flash controller: request register, engine, result register.
// Depends on lffc_pkg, lffc_regs and lffc_engine.
//
//  channel  | group               | payload
//  ---------+---------------------+---------------------------------------------
//  requests | s_tvalid/s_tready   | s_tuser: req_type; s_tdata: level, step, count
//  results  | m_tvalid/m_tready   | m_tdata: drive, flags, current and target
//  config   | psel/penable/pwrite | four 32-bit registers at byte 0, 4, 8, 12
//
// A request is accepted into the request register and passes through the engine
// into the result register, from which its result is offered on m_tdata.
// One request is accepted every cycle while results are taken.
// Reset (rst, synchronous) clears valid flags and engine state, loads register defaults.
// A stalled result holds the engine and the request register at once; s_tready
// falls in the same cycle when both registers are full.
module led_fade_flash_controller #(
  parameter int LEVEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // level_value[15:0], step_value[32:16], flash_count[40:33]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // drive_level[15:0], drive_written[16], accepted[17],
                                 // busy_flag[18], current_level[34:19], target_level[50:35]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lffc_pkg::cfg_t cfg;
  lffc_pkg::req_t req;
  lffc_pkg::res_t res;
  lffc_pkg::res_t res_q;
  logic           req_valid;
  logic           advance;

  lffc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lffc_engine #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_engine (
    .clk (clk),
    .rst (rst),
    .go  (advance),
    .req (req),
    .cfg (cfg),
    .res (res)
  );

  assign advance  = req_valid && (!m_tvalid || m_tready);
  assign s_tready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_tready) begin
      req_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.req_type    <= lffc_pkg::req_type_t'(s_tuser);
      req.level_value <= s_tdata[15:0];
      req.step_value  <= $signed(s_tdata[32:16]);
      req.flash_count <= s_tdata[40:33];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_tdata = {5'd0, res_q.target_level, res_q.current_level, res_q.busy_flag,
                    res_q.accepted, res_q.drive_written, res_q.drive_level};

  // A request that enters the engine always shows up as a result next cycle.
  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed request produced no result");

  // A held request keeps its payload until the engine takes it.
  a_held_request_stable: assert property (@(posedge clk) disable iff (rst)
    req_valid && !advance |=> req_valid && $stable(req))
    else $error("held request was lost or changed");

  // Backpressure reaches the input only when both stages are full and stalled.
  a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> req_valid && m_tvalid && !m_tready)
    else $error("input stalled without a full pipeline");

endmodule

// ----- rtl/core/lffc_regs.sv -----
// Configuration register file with an APB-style write and read port.
// Depends on lffc_pkg for the register indexes, reset values and cfg_t.
module lffc_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output lffc_pkg::cfg_t      cfg
);

  logic              wr_en;
  lffc_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = lffc_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pwm_mode    <= lffc_pkg::PWM_MODE_RST;
      cfg.max_level   <= lffc_pkg::MAX_LEVEL_RST;
      cfg.blink_ticks <= lffc_pkg::BLINK_TICKS_RST;
      cfg.fade_ticks  <= lffc_pkg::FADE_TICKS_RST;
    end else if (wr_en) begin
      case (idx)
        lffc_pkg::REG_PWM_MODE:    cfg.pwm_mode    <= pwdata[0];
        lffc_pkg::REG_MAX_LEVEL:   cfg.max_level   <= pwdata[15:0];
        lffc_pkg::REG_BLINK_TICKS: cfg.blink_ticks <= pwdata[15:0];
        lffc_pkg::REG_FADE_TICKS:  cfg.fade_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lffc_pkg::REG_PWM_MODE:    prdata = {31'd0, cfg.pwm_mode};
      lffc_pkg::REG_MAX_LEVEL:   prdata = {16'd0, cfg.max_level};
      lffc_pkg::REG_BLINK_TICKS: prdata = {16'd0, cfg.blink_ticks};
      lffc_pkg::REG_FADE_TICKS:  prdata = {16'd0, cfg.fade_ticks};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/core/lffc_engine.sv -----
// Controller state and the single-pass update for one request.
// Depends on lffc_pkg for req_t, cfg_t, res_t and the request codes.
module lffc_engine #(
  parameter int LEVEL_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  lffc_pkg::req_t req,
  input  lffc_pkg::cfg_t cfg,
  output lffc_pkg::res_t res
);

  localparam int LW = LEVEL_BITS;

  logic [LW-1:0] level, level_next;
  logic [LW-1:0] target, target_next;
  logic [LW-1:0] driven, driven_next;
  logic [8:0]    dark, dark_next;
  logic [8:0]    bright, bright_next;
  logic [15:0]   elapsed, elapsed_next;
  logic          busy, busy_next;
  logic          wrote;
  logic          ok;

  logic [LW-1:0]      full;
  logic [LW-1:0]      val;
  logic [15:0]        elapsed_inc;
  logic [7:0]         count_eff;
  logic [8:0]         half_periods;
  logic signed [18:0] sum;
  logic signed [18:0] top;
  logic [LW-1:0]      step_target;

  assign full        = cfg.max_level[LW-1:0];
  assign val         = req.level_value[LW-1:0];
  assign elapsed_inc = (elapsed < lffc_pkg::ELAPSED_MAX) ? elapsed + 16'd1 : elapsed;
  assign count_eff   = (req.flash_count == 8'd0) ? 8'd1 : req.flash_count;
  // 2n-1 written as (n-1) with a one shifted in below.
  assign half_periods = {count_eff - 8'd1, 1'b1};

  assign sum = $signed({3'b000, 16'(target)}) + 19'(req.step_value);
  assign top = $signed({3'b000, 16'(full)});

  always_comb begin
    if (sum < 19'sd0) begin
      step_target = '0;
    end else if (sum > top) begin
      step_target = full;
    end else begin
      step_target = sum[LW-1:0];
    end
  end

  always_comb begin
    level_next   = level;
    target_next  = target;
    driven_next  = driven;
    dark_next    = dark;
    bright_next  = bright;
    elapsed_next = elapsed;
    busy_next    = busy;
    wrote        = 1'b0;
    ok           = 1'b0;
    case (req.req_type)
      lffc_pkg::REQ_TICK: begin
        elapsed_next = elapsed_inc;
        if (dark != 9'd0) begin
          if (elapsed_inc >= cfg.blink_ticks) begin
            driven_next  = !dark[0] ? '0 : (cfg.pwm_mode ? level : full);
            wrote        = 1'b1;
            dark_next    = dark - 9'd1;
            elapsed_next = '0;
            busy_next    = 1'b1;
          end
        end else if (bright != 9'd0) begin
          if (elapsed_inc >= cfg.blink_ticks) begin
            driven_next  = !bright[0] ? full : (cfg.pwm_mode ? level : '0);
            wrote        = 1'b1;
            bright_next  = bright - 9'd1;
            elapsed_next = '0;
            busy_next    = 1'b1;
          end
        end else if (cfg.pwm_mode && level != target) begin
          if (elapsed_inc >= cfg.fade_ticks) begin
            level_next   = (target > level) ? level + LW'(1) : level - LW'(1);
            driven_next  = level_next;
            wrote        = 1'b1;
            elapsed_next = '0;
          end
          busy_next = 1'b1;
        end else if (level != target) begin
          // In on/off mode a pending target snaps the LED fully on or off.
          level_next  = (target > level) ? full : '0;
          target_next = level_next;
          driven_next = level_next;
          wrote       = 1'b1;
          busy_next   = 1'b1;
        end else begin
          busy_next = 1'b0;
        end
      end
      lffc_pkg::REQ_SET: begin
        if (level != val) begin
          level_next  = val;
          target_next = val;
          driven_next = val;
          wrote       = 1'b1;
          ok          = 1'b1;
        end
      end
      lffc_pkg::REQ_STEP: begin
        target_next = step_target;
        if (step_target != level) begin
          elapsed_next = '0;
          ok           = 1'b1;
        end
      end
      lffc_pkg::REQ_FADE: begin
        target_next = val;
        ok          = (val != level);
      end
      lffc_pkg::REQ_DARK: begin
        if (level != '0) begin
          dark_next    = half_periods;
          driven_next  = '0;
          wrote        = 1'b1;
          elapsed_next = '0;
          ok           = 1'b1;
        end
      end
      lffc_pkg::REQ_FLASH: begin
        if (level != full) begin
          bright_next  = half_periods;
          driven_next  = full;
          wrote        = 1'b1;
          elapsed_next = '0;
          ok           = 1'b1;
        end
      end
      lffc_pkg::REQ_ON: begin
        level_next  = full;
        target_next = full;
        driven_next = full;
        wrote       = 1'b1;
        ok          = 1'b1;
      end
      lffc_pkg::REQ_OFF: begin
        level_next  = '0;
        target_next = '0;
        driven_next = '0;
        wrote       = 1'b1;
        ok          = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= '0;
      target  <= '0;
      driven  <= '0;
      dark    <= '0;
      bright  <= '0;
      elapsed <= '0;
      busy    <= 1'b0;
    end else if (go) begin
      level   <= level_next;
      target  <= target_next;
      driven  <= driven_next;
      dark    <= dark_next;
      bright  <= bright_next;
      elapsed <= elapsed_next;
      busy    <= busy_next;
    end
  end

  assign res.drive_level   = 16'(driven_next);
  assign res.drive_written = wrote;
  assign res.accepted      = ok;
  assign res.busy_flag     = busy_next;
  assign res.current_level = 16'(level_next);
  assign res.target_level  = 16'(target_next);

  // The drive level changes only on a request that reports a rewrite.
  a_drive_only_on_write: assert property (@(posedge clk) disable iff (rst)
    go && !wrote |=> $stable(driven))
    else $error("drive level changed without a rewrite");

  // Only a flash or dark request or a tick can leave a flash sequence pending.
  a_flash_source: assert property (@(posedge clk) disable iff (rst)
    go && (req.req_type == lffc_pkg::REQ_SET || req.req_type == lffc_pkg::REQ_FADE)
    |=> $stable(dark) && $stable(bright))
    else $error("flash counters moved on a level request");

  // Without a request in the engine the controller state holds.
  a_idle_holds_state: assert property (@(posedge clk) disable iff (rst)
    !go |=> $stable(level) && $stable(target) && $stable(elapsed))
    else $error("controller state moved without a request");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for led_fade_flash_controller: directed and random requests
// are streamed in, every result is compared with a built-in predictor of the controller.
// Depends on lffc_pkg and the led_fade_flash_controller RTL.
module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int CHOKE_CYCLES = 400;

  typedef struct {
    lffc_pkg::req_t req;
    bit             hold;   // wait for all outstanding results before offering this request
  } queued_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // level_value[15:0], step_value[32:16], flash_count[40:33]
  logic [2:0]  s_tuser = '0;   // req_type[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // drive_level[15:0], drive_written[16], accepted[17],
                               // busy_flag[18], current_level[34:19], target_level[50:35]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  led_fade_flash_controller i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predicted controller state and register copy.
  logic        cfg_pwm = lffc_pkg::PWM_MODE_RST;
  logic [15:0] cfg_max = lffc_pkg::MAX_LEVEL_RST;
  logic [15:0] cfg_blink = lffc_pkg::BLINK_TICKS_RST;
  logic [15:0] cfg_fade = lffc_pkg::FADE_TICKS_RST;
  logic [15:0] lvl = '0;
  logic [15:0] tgt = '0;
  logic [8:0]  dark_left = '0;
  logic [8:0]  bright_left = '0;
  logic [15:0] ticks_since = '0;
  logic        busy_q = 1'b0;
  logic [15:0] drive_q = '0;

  queued_req_t    req_queue[$];
  lffc_pkg::res_t outcomes_due[$];
  lffc_pkg::req_t on_bus;
  int             gap_left = 0;
  int             stall_left = 0;
  int             choke_left = 0;
  int             choke_asks = 0;
  int             choke_served = 0;
  int             queued_total = 0;
  int             results_seen = 0;
  int             fail_count = 0;
  bit             quiet = 1'b0;
  int unsigned    cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Applies one request to the predicted state and returns the result it should produce.
  function automatic lffc_pkg::res_t led_react(lffc_pkg::req_t r);
    lffc_pkg::res_t o;
    int             sum;
    logic [8:0]     span;
    logic           ok;
    logic           wrote;
    ok = 1'b0;
    wrote = 1'b0;
    // A flash count of zero still gives one flash; n flashes are 2n-1 half periods.
    span = (r.flash_count == 8'd0) ? 9'd1 : {r.flash_count, 1'b0} - 9'd1;
    case (r.req_type)
      lffc_pkg::REQ_TICK: begin
        if (ticks_since != lffc_pkg::ELAPSED_MAX) ticks_since = ticks_since + 16'd1;
        if (dark_left != 0) begin
          if (ticks_since >= cfg_blink) begin
            drive_q = dark_left[0] ? (cfg_pwm ? lvl : cfg_max) : 16'd0;
            wrote = 1'b1;
            dark_left = dark_left - 9'd1;
            ticks_since = '0;
            busy_q = 1'b1;
          end
        end else if (bright_left != 0) begin
          if (ticks_since >= cfg_blink) begin
            drive_q = bright_left[0] ? (cfg_pwm ? lvl : 16'd0) : cfg_max;
            wrote = 1'b1;
            bright_left = bright_left - 9'd1;
            ticks_since = '0;
            busy_q = 1'b1;
          end
        end else if (cfg_pwm && lvl != tgt) begin
          if (ticks_since >= cfg_fade) begin
            lvl = (tgt > lvl) ? lvl + 16'd1 : lvl - 16'd1;
            drive_q = lvl;
            wrote = 1'b1;
            ticks_since = '0;
          end
          busy_q = 1'b1;
        end else if (lvl != tgt) begin
          lvl = (tgt > lvl) ? cfg_max : 16'd0;
          tgt = lvl;
          drive_q = lvl;
          wrote = 1'b1;
          busy_q = 1'b1;
        end else begin
          busy_q = 1'b0;
        end
      end
      lffc_pkg::REQ_SET: begin
        if (lvl != r.level_value) begin
          lvl = r.level_value;
          tgt = r.level_value;
          drive_q = r.level_value;
          wrote = 1'b1;
          ok = 1'b1;
        end
      end
      lffc_pkg::REQ_STEP: begin
        sum = int'(tgt) + int'($signed(r.step_value));
        if (sum < 0) tgt = '0;
        else if (sum > int'(cfg_max)) tgt = cfg_max;
        else tgt = sum[15:0];
        if (tgt != lvl) begin
          ticks_since = '0;
          ok = 1'b1;
        end
      end
      lffc_pkg::REQ_FADE: begin
        tgt = r.level_value;
        ok = (r.level_value != lvl);
      end
      lffc_pkg::REQ_DARK: begin
        if (lvl != 0) begin
          dark_left = span;
          drive_q = '0;
          wrote = 1'b1;
          ticks_since = '0;
          ok = 1'b1;
        end
      end
      lffc_pkg::REQ_FLASH: begin
        if (lvl != cfg_max) begin
          bright_left = span;
          drive_q = cfg_max;
          wrote = 1'b1;
          ticks_since = '0;
          ok = 1'b1;
        end
      end
      lffc_pkg::REQ_ON: begin
        lvl = cfg_max;
        tgt = cfg_max;
        drive_q = cfg_max;
        wrote = 1'b1;
        ok = 1'b1;
      end
      default: begin
        lvl = '0;
        tgt = '0;
        drive_q = '0;
        wrote = 1'b1;
        ok = 1'b1;
      end
    endcase
    o.drive_level = drive_q;
    o.drive_written = wrote;
    o.accepted = ok;
    o.busy_flag = busy_q;
    o.current_level = lvl;
    o.target_level = tgt;
    return o;
  endfunction

  // Request driver: the outcome of a request is predicted at the edge that accepts it.
  always @(posedge clk) begin : req_driver
    int idle;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        outcomes_due.push_back(led_react(on_bus));
        idle = quiet ? 0 : $urandom_range(0, 13);
      end else begin
        idle = gap_left;
      end
      if (s_tvalid && !s_tready) begin
        gap_left <= idle;
      end else if (idle != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= idle - 1;
      end else if (req_queue.size() != 0 &&
                   !(req_queue[0].hold && outcomes_due.size() != 0)) begin
        on_bus = req_queue[0].req;
        req_queue.pop_front();
        s_tdata <= {7'd0, on_bus.flash_count, on_bus.step_value, on_bus.level_value};
        s_tuser <= on_bus.req_type;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin : result_monitor
    int             wait_n;
    lffc_pkg::res_t got;
    lffc_pkg::res_t want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
      choke_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.drive_level = m_tdata[15:0];
        got.drive_written = m_tdata[16];
        got.accepted = m_tdata[17];
        got.busy_flag = m_tdata[18];
        got.current_level = m_tdata[34:19];
        got.target_level = m_tdata[50:35];
        if (outcomes_due.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = outcomes_due.pop_front();
          results_seen++;
          if (got.drive_level !== want.drive_level) begin
            $error("drive_level: expected %0d, got %0d", want.drive_level, got.drive_level);
            fail_count++;
          end
          if (got.drive_written !== want.drive_written) begin
            $error("drive_written: expected %0d, got %0d",
                   want.drive_written, got.drive_written);
            fail_count++;
          end
          if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            fail_count++;
          end
          if (got.busy_flag !== want.busy_flag) begin
            $error("busy_flag: expected %0d, got %0d", want.busy_flag, got.busy_flag);
            fail_count++;
          end
          if (got.current_level !== want.current_level) begin
            $error("current_level: expected %0d, got %0d",
                   want.current_level, got.current_level);
            fail_count++;
          end
          if (got.target_level !== want.target_level) begin
            $error("target_level: expected %0d, got %0d",
                   want.target_level, got.target_level);
            fail_count++;
          end
        end
        wait_n = quiet ? 0 : $urandom_range(0, 13);
      end else begin
        wait_n = stall_left;
      end
      if (choke_asks != choke_served) begin
        choke_served <= choke_asks;
        choke_left <= CHOKE_CYCLES;
        m_tready <= 1'b0;
        stall_left <= wait_n;
      end else if (choke_left != 0) begin
        choke_left <= choke_left - 1;
        m_tready <= 1'b0;
        stall_left <= wait_n;
      end else if (wait_n != 0) begin
        m_tready <= 1'b0;
        stall_left <= wait_n - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_req(lffc_pkg::req_type_t t, logic [15:0] lv, logic [16:0] st,
                          logic [7:0] cnt, bit hold);
    queued_req_t q;
    q.req.req_type = t;
    q.req.level_value = lv;
    q.req.step_value = st;
    q.req.flash_count = cnt;
    q.hold = hold;
    req_queue.push_back(q);
    queued_total++;
  endtask

  // Mostly ticks and small steps and flash counts so that fades and flashes run their
  // course; full-range values are mixed in for the corners.
  task automatic push_random(int count);
    lffc_pkg::req_type_t t;
    logic [15:0]         lv;
    logic [7:0]          cnt;
    int                  pick;
    int                  s;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) t = lffc_pkg::REQ_TICK;
      else if (pick < 55) t = lffc_pkg::REQ_SET;
      else if (pick < 65) t = lffc_pkg::REQ_STEP;
      else if (pick < 75) t = lffc_pkg::REQ_FADE;
      else if (pick < 82) t = lffc_pkg::REQ_DARK;
      else if (pick < 89) t = lffc_pkg::REQ_FLASH;
      else if (pick < 94) t = lffc_pkg::REQ_ON;
      else t = lffc_pkg::REQ_OFF;
      lv = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, cfg_max));
      s = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 131070)) - 65535
                                      : int'($urandom_range(0, 8)) - 4;
      cnt = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      push_req(t, lv, 17'(s), cnt, $urandom_range(0, 59) == 0);
    end
  endtask

  task automatic apb_write(lffc_pkg::reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      lffc_pkg::REG_PWM_MODE:    cfg_pwm = val[0];
      lffc_pkg::REG_MAX_LEVEL:   cfg_max = val;
      lffc_pkg::REG_BLINK_TICKS: cfg_blink = val;
      default:                   cfg_fade = val;
    endcase
  endtask

  task automatic set_config(bit pwm, logic [15:0] mx, logic [15:0] bl, logic [15:0] fd);
    apb_write(lffc_pkg::REG_PWM_MODE, {15'd0, pwm});
    apb_write(lffc_pkg::REG_MAX_LEVEL, mx);
    apb_write(lffc_pkg::REG_BLINK_TICKS, bl);
    apb_write(lffc_pkg::REG_FADE_TICKS, fd);
  endtask

  // Every request yields one result, so all results in means the controller is idle.
  task automatic wait_idle();
    while (results_seen != queued_total) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset register values.
    push_req(lffc_pkg::REQ_TICK, 16'd0, 17'd0, 8'd0, 0);
    push_req(lffc_pkg::REQ_SET, 16'd0, 17'd0, 8'd0, 0);
    push_req(lffc_pkg::REQ_SET, 16'hFFFF, 17'h1FFFF, 8'hFF, 0);
    push_req(lffc_pkg::REQ_FADE, 16'd0, 17'd0, 8'd0, 0);
    push_req(lffc_pkg::REQ_TICK, 16'd0, 17'd0, 8'd0, 0);
    push_req(lffc_pkg::REQ_SET, 16'd100, 17'h0AAAA, 8'hAA, 0);
    push_req(lffc_pkg::REQ_STEP, 16'h5555, 17'd65535, 8'd0, 0);
    push_req(lffc_pkg::REQ_TICK, 16'd0, 17'd0, 8'd0, 0);
    push_req(lffc_pkg::REQ_STEP, 16'hAAAA, -17'sd65535, 8'd0, 0);
    push_req(lffc_pkg::REQ_FADE, 16'hAAAA, 17'h15555, 8'h55, 0);
    push_req(lffc_pkg::REQ_OFF, 16'd0, 17'd0, 8'd0, 0);
    push_req(lffc_pkg::REQ_DARK, 16'd0, 17'd0, 8'd0, 0);
    push_req(lffc_pkg::REQ_ON, 16'd0, 17'd0, 8'd0, 0);
    push_req(lffc_pkg::REQ_FLASH, 16'd0, 17'd0, 8'd0, 0);
    push_req(lffc_pkg::REQ_DARK, 16'd0, 17'd0, 8'd0, 0);
    push_req(lffc_pkg::REQ_TICK, 16'd0, 17'd0, 8'd0, 0);
    push_req(lffc_pkg::REQ_SET, 16'd128, 17'd0, 8'd0, 1);
    push_req(lffc_pkg::REQ_FLASH, 16'd0, 17'd0, 8'd255, 0);
    push_req(lffc_pkg::REQ_DARK, 16'd0, 17'd0, 8'd1, 0);
    push_req(lffc_pkg::REQ_TICK, 16'd0, 17'd0, 8'd0, 0);
    push_req(lffc_pkg::REQ_STEP, 16'd0, 17'd0, 8'd0, 0);
    push_req(lffc_pkg::REQ_OFF, 16'd0, 17'd0, 8'd0, 0);
    push_req(lffc_pkg::REQ_ON, 16'd0, 17'd0, 8'd0, 0);
    wait_idle();

    set_config(1'b1, 16'd255, 16'd3, 16'd1);
    push_random(250);
    wait_idle();

    // On/off only, with a one-level range.
    set_config(1'b0, 16'd1, 16'd1, 16'd2);
    push_random(200);
    wait_idle();

    // Long receiver hold-off while requests keep coming.
    set_config(1'b1, 16'd65535, 16'd1, 16'd4);
    push_random(200);
    choke_asks++;
    wait_idle();

    // Zero periods act on every tick.
    set_config(1'b0, 16'd40000, 16'd0, 16'd0);
    push_random(150);
    wait_idle();

    set_config(1'b1, 16'd20, 16'd0, 16'd0);
    push_random(150);
    wait_idle();

    set_config(1'b1, 16'd65535, 16'd65535, 16'd65535);
    push_random(100);
    wait_idle();

    set_config(1'b1, 16'd1, 16'd5, 16'd1);
    push_random(150);
    wait_idle();

    // Back-to-back requests with the receiver always ready.
    quiet = 1'b1;
    set_config(1'b1, 16'd255, 16'd2, 16'd3);
    push_random(40);
    wait_idle();
    quiet = 1'b0;

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
